>>> rtl/itb_pkg.sv
// Shared constants, codes and control structs for the interval timer bank.
package itb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TIMER_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int IDX_W      = 4;
  localparam int TICK_W     = 16;
  localparam int PERIOD_W   = 24;
  localparam int PENDING_W  = 32;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_QUERY = 2'd3
  } itb_mode_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [IDX_W-1:0]    timer_index;
    logic [TICK_W-1:0]   tick_ms;
    logic [PERIOD_W-1:0] interval_ms;
  } itb_item_t;

  typedef struct packed {
    logic               tick;
    logic               start;
    logic               stop;
    logic               query;
    logic               walk;
    logic [TIMER_W-1:0] walk_idx;
    logic               finish;
    logic               load_zero;
  } itb_cmd_t;

  typedef struct packed {
    logic pending_zero;
  } itb_status_t;

endpackage

>>> rtl/itb_if.sv
// Valid/ready channel interfaces for the timer bank's item and result beats.
interface itb_in_if;
  import itb_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [IDX_W-1:0]    timer_index;
  logic [TICK_W-1:0]   tick_ms;
  logic [PERIOD_W-1:0] interval_ms;

  modport source (output valid, output mode, output timer_index, output tick_ms,
                  output interval_ms, input ready);
  modport sink   (input valid, input mode, input timer_index, input tick_ms,
                  input interval_ms, output ready);
endinterface

interface itb_out_if;
  logic valid;
  logic ready;
  logic expired;

  modport source (output valid, output expired, input ready);
  modport sink   (input valid, input expired, output ready);
endinterface

>>> rtl/itb_ctrl.sv
// Controller: sequences beats, walks the timers on a query and owns the result valid.
module itb_ctrl
  import itb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_mode,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  itb_status_t status,
  output itb_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t             state_r;
  logic [TIMER_W-1:0] walk_cnt_r;
  logic               out_valid_r;
  logic               slot_free;
  logic               accept;
  logic               walk_last;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign walk_last = (walk_cnt_r == TIMER_W'(NUM_TIMERS - 1));
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.tick      = accept && (in_mode == MODE_TICK);
    cmd.start     = accept && (in_mode == MODE_START);
    cmd.stop      = accept && (in_mode == MODE_STOP);
    cmd.query     = accept && (in_mode == MODE_QUERY);
    cmd.load_zero = accept && (in_mode != MODE_QUERY);
    cmd.walk      = (state_r == S_WALK);
    cmd.walk_idx  = walk_cnt_r;
    cmd.finish    = (state_r == S_FINISH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_zero || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          walk_cnt_r <= '0;
          if (cmd.query) begin
            // With nothing pending the timers would not change, so skip the walk.
            state_r <= status.pending_zero ? S_FINISH : S_WALK;
          end
        end
        S_WALK: begin
          if (walk_last) begin
            state_r <= S_FINISH;
          end else begin
            walk_cnt_r <= walk_cnt_r + 1'b1;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("input ready outside idle");

  a_plain_beat_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_zero |=> out_valid_r)
    else $error("non-query beat produced no result");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("query finish did not deliver a result");

  a_walk_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WALK) && out_ready) |=> !out_valid_r)
    else $error("result appeared during the timer walk");

endmodule

>>> rtl/itb_datapath.sv
// Datapath: accumulator, timer period/remaining/flag stores and the result register.
module itb_datapath
  import itb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  itb_item_t   item,
  input  itb_cmd_t    cmd,
  output itb_status_t status,
  output logic        out_expired
);

  logic [PENDING_W-1:0] pending_r;
  logic [PENDING_W-1:0] amount_r;
  logic [TIMER_W-1:0]   qidx_r;
  logic                 qvalid_r;
  logic                 out_expired_r;
  logic [PERIOD_W-1:0]  period_r  [NUM_TIMERS];
  logic [PERIOD_W-1:0]  remain_r  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] flag_r;

  logic [PENDING_W:0]   tick_sum;
  logic [PENDING_W-1:0] pending_nxt;
  logic                 item_valid;
  logic [TIMER_W-1:0]   item_idx;
  logic [PERIOD_W-1:0]  walk_period;
  logic [PERIOD_W-1:0]  walk_remain;
  logic                 walk_expire;

  assign tick_sum    = {1'b0, pending_r} + {{(PENDING_W + 1 - TICK_W){1'b0}}, item.tick_ms};
  assign pending_nxt = tick_sum[PENDING_W] ? {PENDING_W{1'b1}} : tick_sum[PENDING_W-1:0];
  assign item_valid  = ({1'b0, item.timer_index} < (IDX_W + 1)'(NUM_TIMERS));
  assign item_idx    = item.timer_index[TIMER_W-1:0];
  assign walk_period = period_r[cmd.walk_idx];
  assign walk_remain = remain_r[cmd.walk_idx];
  // Running counts stay within 1..period, so an unsigned compare covers "reaches zero or less".
  assign walk_expire = ({{(PENDING_W - PERIOD_W){1'b0}}, walk_remain} <= amount_r);

  assign status.pending_zero = (pending_r == '0);
  assign out_expired         = out_expired_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      flag_r    <= '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        period_r[t] <= '0;
        remain_r[t] <= '0;
      end
    end else begin
      if (cmd.tick) begin
        pending_r <= pending_nxt;
      end else if (cmd.query) begin
        pending_r <= '0;
      end
      if (cmd.start && item_valid) begin
        flag_r[item_idx]   <= 1'b0;
        period_r[item_idx] <= item.interval_ms;
        remain_r[item_idx] <= item.interval_ms;
      end
      if (cmd.stop && item_valid) begin
        period_r[item_idx] <= '0;
      end
      if (cmd.walk && (walk_period != '0)) begin
        if (walk_expire) begin
          remain_r[cmd.walk_idx] <= walk_period;
          flag_r[cmd.walk_idx]   <= 1'b1;
        end else begin
          remain_r[cmd.walk_idx] <= walk_remain - amount_r[PERIOD_W-1:0];
        end
      end
      if (cmd.finish && qvalid_r) begin
        flag_r[qidx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      amount_r <= pending_r;
      qidx_r   <= item_idx;
      qvalid_r <= item_valid;
    end
    if (cmd.load_zero) begin
      out_expired_r <= 1'b0;
    end else if (cmd.finish) begin
      out_expired_r <= qvalid_r && flag_r[qidx_r];
    end
  end

endmodule

>>> rtl/interval_timer_bank_unit.sv
// Result timing: tick, start and stop beats give their result in the cycle after acceptance.
// A query walks the timer stores one entry per cycle (skipped with nothing pending),
// then gives its result from the finish state once the result slot is free.
// Throughput: one item at a time; a new item is taken once the result slot is free.
// Reset (rst_n low, synchronous): accumulator zero, all timers stopped with zero
// counts and clear flags, no result pending.
module interval_timer_bank_unit
  import itb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  itb_in_if.sink     in_bus,
  itb_out_if.source  out_bus
);

  itb_cmd_t    cmd;
  itb_status_t status;
  itb_item_t   item;

  assign item.mode        = in_bus.mode;
  assign item.timer_index = in_bus.timer_index;
  assign item.tick_ms     = in_bus.tick_ms;
  assign item.interval_ms = in_bus.interval_ms;

  itb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_mode   (in_bus.mode),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .status    (status),
    .cmd       (cmd)
  );

  itb_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .out_expired (out_bus.expired)
  );

endmodule
